### rtl/occ_pkg.sv
// ----------------------------------------------------------------------------
// occ_pkg
// Shared widths, codes and command word of the online covariance accumulator.
// ----------------------------------------------------------------------------
package occ_pkg;

  // vector dimension and derived widths
  localparam int DIM     = 8;
  localparam int DIM_W   = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int N_W     = $clog2(DIM + 1);
  localparam int ENT_W   = $clog2(DIM * DIM);
  localparam int CFG_W   = 7;
  localparam int CNT_W   = 24;
  localparam int MEAN_W  = 24;
  localparam int COV_W   = 32;
  localparam int D_W     = 25;
  localparam int T_W     = 2 * D_W;
  localparam int DEN_W   = CNT_W + 1;
  localparam int DIV_W   = 52;
  localparam int DIMS_RESET = 8;

  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [MEAN_W-1:0] MEAN_MAX  = {MEAN_W{1'b1}};

  // input word kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // configuration register addresses
  localparam logic [1:0] ADDR_DIMS = 2'd0;

  typedef enum logic [1:0] {
    OP_VEC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // command passed from the front to the back
  typedef struct packed {
    op_e                  op;
    logic [5:0]           row;
    logic [5:0]           col;
    logic [DIM*8-1:0]     vec;
    logic [N_W-1:0]       n;
  } cmd_t;

endpackage

### rtl/occ_div.sv
// ----------------------------------------------------------------------------
// occ_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module occ_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [occ_pkg::DIV_W-1:0] num_i,
  input  logic [occ_pkg::DEN_W-1:0] den_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [occ_pkg::DIV_W-1:0] quot_o
);
  import occ_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    fits   = (rem_sh >= {1'b0, den_q});
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### rtl/occ_front.sv
// ----------------------------------------------------------------------------
// occ_front
// Accepts input words, assembles sample vectors and queues commands.
// ----------------------------------------------------------------------------
module occ_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                kind_i,
  input  logic [7:0]                value_i,
  input  logic [5:0]                row_i,
  input  logic [5:0]                col_i,
  input  logic [occ_pkg::CFG_W-1:0] dims_i,
  output logic                      cmd_valid_o,
  output occ_pkg::cmd_t             cmd_o,
  input  logic                      cmd_pop_i
);
  import occ_pkg::*;

  logic [DIM_W-1:0] pos_q;
  logic [7:0]       buf_q [DIM];
  logic [N_W-1:0]   n_act;
  logic [N_W-1:0]   pos_inc;
  logic [DIM*8-1:0] vec_next;
  logic             accept, push, last_elem;
  cmd_t             push_cmd;
  cmd_t             fifo_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  // active vector length
  always_comb begin
    if (dims_i == '0)                 n_act = N_W'(1);
    else if (dims_i > CFG_W'(DIM))    n_act = N_W'(DIM);
    else                              n_act = N_W'(dims_i);
  end

  assign accept    = in_valid_i && !in_stall_o;
  assign pos_inc   = N_W'(pos_q) + 1'b1;
  assign last_elem = (pos_inc >= n_act);

  // vector with the incoming element merged in
  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      vec_next[k*8 +: 8] = (DIM_W'(k) == pos_q) ? value_i : buf_q[k];
    end
  end

  // classify the word
  always_comb begin
    push         = 1'b0;
    push_cmd.op  = OP_READ;
    push_cmd.row = row_i;
    push_cmd.col = col_i;
    push_cmd.vec = vec_next;
    push_cmd.n   = n_act;
    if (accept) begin
      case (kind_i)
        KIND_SAMPLE: begin
          push        = last_elem;
          push_cmd.op = OP_VEC;
        end
        KIND_READ: begin
          push        = 1'b1;
          push_cmd.op = OP_READ;
        end
        KIND_CLEAR: begin
          push        = 1'b1;
          push_cmd.op = OP_CLEAR;
        end
        default: push = 1'b0;
      endcase
    end
  end

  // element position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      if (kind_i == KIND_SAMPLE) pos_q <= last_elem ? '0 : DIM_W'(pos_inc);
      else if (kind_i == KIND_CLEAR) pos_q <= '0;
    end
  end

  // sample buffer
  always_ff @(posedge clk_i) begin
    if (accept && kind_i == KIND_SAMPLE) buf_q[pos_q] <= value_i;
  end

  // two-entry command queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (cmd_pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= push_cmd;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_q];

endmodule

### rtl/occ_back.sv
// ----------------------------------------------------------------------------
// occ_back
// Executes queued commands: mean and covariance update, reads and clears.
// ----------------------------------------------------------------------------
module occ_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  occ_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       div_start_o,
  output logic [occ_pkg::DIV_W-1:0]  div_num_o,
  output logic [occ_pkg::DEN_W-1:0]  div_den_o,
  input  logic                       div_done_i,
  input  logic [occ_pkg::DIV_W-1:0]  div_quot_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [31:0]         covariance_o,
  output logic [23:0]                row_mean_o,
  output logic [23:0]                sample_count_o
);
  import occ_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD_REQ = 4'd1;
  localparam logic [3:0] S_RD_OUT = 4'd2;
  localparam logic [3:0] S_M_MUL  = 4'd3;
  localparam logic [3:0] S_M_DIV  = 4'd4;
  localparam logic [3:0] S_M_WAIT = 4'd5;
  localparam logic [3:0] S_C_ROW  = 4'd6;
  localparam logic [3:0] S_C_RD   = 4'd7;
  localparam logic [3:0] S_C_P    = 4'd8;
  localparam logic [3:0] S_C_W1   = 4'd9;
  localparam logic [3:0] S_C_T    = 4'd10;
  localparam logic [3:0] S_C_W2   = 4'd11;

  logic [3:0]               state_q;
  cmd_t                     cmd_q;
  logic [DIM_W-1:0]         i_q, j_q;
  logic [MEAN_W-1:0]        mean_q [DIM];
  logic [CNT_W-1:0]         cnt_q;
  logic [DIM*DIM-1:0]       valid_q;
  logic signed [D_W-1:0]    d_q [DIM];
  logic signed [D_W-1:0]    di_q;
  logic [2*MEAN_W-1:0]      prod_q;
  logic signed [T_W-1:0]    p_q, t_q;
  logic signed [COV_W-1:0]  cov_q;
  logic                     neg_q;
  logic [COV_W-1:0]         mem [DIM*DIM];
  logic [COV_W-1:0]         rdata_q;
  logic                     rvalid_q;
  logic                     out_valid_q;
  logic signed [COV_W-1:0]  out_cov_q;
  logic [MEAN_W-1:0]        out_mean_q, out_cnt_q;

  logic [DEN_W-1:0]         nn;
  logic [7:0]               x_i;
  logic [MEAN_W-1:0]        old_i;
  logic [ENT_W-1:0]         mem_addr;
  logic                     mem_rd, mem_we;
  logic [COV_W-1:0]         mem_wdata;
  logic                     row_ok, col_ok;
  logic [ENT_W-1:0]         rd_addr, upd_addr;
  logic signed [T_W-1:0]    quot_s, t2;
  logic [T_W-1:0]           mag2, cm;
  logic signed [COV_W-1:0]  c_sat;
  logic                     out_free, last_j, last_i;

  assign nn       = DEN_W'(cnt_q) + 1'b1;
  assign x_i      = cmd_q.vec[i_q*8 +: 8];
  assign old_i    = mean_q[i_q];
  assign row_ok   = ({1'b0, cmd_q.row} < 7'(DIM));
  assign col_ok   = ({1'b0, cmd_q.col} < 7'(DIM));
  assign rd_addr  = ENT_W'(cmd_q.row * DIM + cmd_q.col);
  assign upd_addr = ENT_W'(i_q * DIM + j_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign last_j   = (j_q == DIM_W'(DIM - 1));
  assign last_i   = (N_W'(i_q) + 1'b1 == cmd_q.n);
  assign quot_s   = neg_q ? -$signed(T_W'(div_quot_i)) : $signed(T_W'(div_quot_i));

  // final rounding to Q15.16 with saturation
  always_comb begin
    t2   = t_q - quot_s;
    mag2 = t2[T_W-1] ? T_W'(-t2) : T_W'(t2);
    cm   = (mag2 + T_W'(32768)) >> 16;
    if (!t2[T_W-1]) begin
      c_sat = (cm > T_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff : $signed(COV_W'(cm));
    end else begin
      c_sat = (cm > T_W'(33'h0_8000_0000)) ? $signed(32'h8000_0000)
                                           : $signed(COV_W'(-cm));
    end
  end

  // memory port control
  always_comb begin
    mem_rd    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = upd_addr;
    mem_wdata = c_sat;
    if (state_q == S_RD_REQ) begin
      mem_rd   = 1'b1;
      mem_addr = rd_addr;
    end else if (state_q == S_C_RD && N_W'(j_q) < cmd_q.n) begin
      mem_rd = 1'b1;
    end else if (state_q == S_C_W2 && div_done_i) begin
      mem_we = 1'b1;
    end
  end

  // divider operands
  always_comb begin
    div_start_o = 1'b0;
    div_den_o   = nn;
    div_num_o   = '0;
    case (state_q)
      S_M_DIV: begin
        div_start_o = 1'b1;
        div_num_o   = DIV_W'(prod_q) + (DIV_W'(x_i) << 16) + DIV_W'(nn >> 1);
      end
      S_C_P: begin
        div_start_o = 1'b1;
        div_num_o   = DIV_W'(p_q[T_W-1] ? -p_q : p_q) + DIV_W'(nn >> 1);
      end
      S_C_T: begin
        div_start_o = 1'b1;
        div_num_o   = DIV_W'(t_q[T_W-1] ? -t_q : t_q) + DIV_W'(nn >> 1);
      end
      default: div_start_o = 1'b0;
    endcase
  end

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  // covariance store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_rd) begin
      rdata_q  <= mem[mem_addr];
      rvalid_q <= valid_q[mem_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      for (int k = 0; k < DIM; k++) mean_q[k] <= '0;
    end else begin
      // result word handshake
      if (state_q == S_RD_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.op)
              OP_READ: state_q <= S_RD_REQ;
              OP_CLEAR: begin
                valid_q <= '0;
                cnt_q   <= '0;
                for (int k = 0; k < DIM; k++) mean_q[k] <= '0;
              end
              OP_VEC: begin
                if (cnt_q == '0) begin
                  // first sample sets the mean
                  valid_q <= '0;
                  cnt_q   <= CNT_W'(1);
                  for (int k = 0; k < DIM; k++) begin
                    mean_q[k] <= (N_W'(k) < cmd_i.n) ? {cmd_i.vec[k*8 +: 8], 16'h0} : '0;
                  end
                end else begin
                  i_q     <= '0;
                  state_q <= S_M_MUL;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_RD_REQ: state_q <= S_RD_OUT;
        S_RD_OUT: begin
          if (out_free) begin
            out_cov_q   <= (row_ok && col_ok && rvalid_q) ? $signed(rdata_q) : '0;
            out_mean_q  <= row_ok ? mean_q[DIM_W'(cmd_q.row)] : '0;
            out_cnt_q   <= cnt_q;
            state_q     <= S_IDLE;
          end
        end
        S_M_MUL: state_q <= S_M_DIV;
        S_M_DIV: state_q <= S_M_WAIT;
        S_M_WAIT: begin
          if (div_done_i) begin
            mean_q[i_q] <= (div_quot_i > DIV_W'(MEAN_MAX)) ? MEAN_MAX
                                                           : MEAN_W'(div_quot_i);
            if (last_i) begin
              i_q     <= '0;
              j_q     <= '0;
              state_q <= S_C_ROW;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_M_MUL;
            end
          end
        end
        S_C_ROW: state_q <= S_C_RD;
        S_C_RD: begin
          if (N_W'(j_q) < cmd_q.n) begin
            state_q <= S_C_P;
          end else if (last_j) begin
            j_q <= '0;
            if (last_i) begin
              if (cnt_q != COUNT_MAX) cnt_q <= cnt_q + 1'b1;
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_C_ROW;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_C_P:  state_q <= S_C_W1;
        S_C_W1: if (div_done_i) state_q <= S_C_T;
        S_C_T:  state_q <= S_C_W2;
        S_C_W2: begin
          if (div_done_i) begin
            valid_q[upd_addr] <= 1'b1;
            if (last_j) begin
              j_q <= '0;
              if (last_i) begin
                if (cnt_q != COUNT_MAX) cnt_q <= cnt_q + 1'b1;
                state_q <= S_IDLE;
              end else begin
                i_q     <= i_q + 1'b1;
                state_q <= S_C_ROW;
              end
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= S_C_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    case (state_q)
      S_M_MUL: begin
        prod_q   <= old_i * cnt_q;
        d_q[i_q] <= $signed({1'b0, x_i, 16'h0}) - $signed({1'b0, old_i});
      end
      S_C_ROW: di_q <= d_q[i_q];
      S_C_P: begin
        cov_q <= rvalid_q ? $signed(rdata_q) : '0;
        neg_q <= p_q[T_W-1];
      end
      S_C_W1: if (div_done_i) t_q <= ($signed(T_W'(cov_q)) <<< 16) + quot_s;
      S_C_T:  neg_q <= t_q[T_W-1];
      default: neg_q <= neg_q;
    endcase
    if (state_q == S_C_RD) p_q <= di_q * d_q[0];
    // rotate the difference line once per column step
    if ((state_q == S_C_RD && N_W'(j_q) >= cmd_q.n) ||
        (state_q == S_C_W2 && div_done_i)) begin
      for (int k = 0; k < DIM - 1; k++) d_q[k] <= d_q[k+1];
      d_q[DIM-1] <= d_q[0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign covariance_o   = out_cov_q;
  assign row_mean_o     = out_mean_q;
  assign sample_count_o = out_cnt_q;

endmodule

### rtl/online_covariance_accumulator.sv
// ----------------------------------------------------------------------------
// online_covariance_accumulator
// Welford update of a running mean vector and population covariance matrix.
// A read word waits in the command queue until the back is idle, then passes
// through S_RD_REQ and S_RD_OUT before its result is registered at the output.
// Elements are taken one per cycle while the command queue has room; a completed
// vector after the first occupies the back for one mean divide per active element
// and two divides per entry in the one-bit-per-cycle divider (52 steps).
// Reset: asynchronous, clears count, means and entry valid bits at once.
// ----------------------------------------------------------------------------
module online_covariance_accumulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         value_i,
  input  logic [5:0]         row_i,
  input  logic [5:0]         col_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] covariance_o,
  output logic [23:0]        row_mean_o,
  output logic [23:0]        sample_count_o
);
  import occ_pkg::*;

  logic [CFG_W-1:0] dims_q;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  logic             div_start, div_busy, div_done;
  logic [DIV_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0] div_den;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= CFG_W'(DIMS_RESET);
    end else if (psel && penable && pwrite && paddr == ADDR_DIMS) begin
      dims_q <= pwdata[CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_DIMS) ? 32'(dims_q) : '0;

  occ_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .dims_i      (dims_q),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  occ_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  occ_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .div_start_o    (div_start),
    .div_num_o      (div_num),
    .div_den_o      (div_den),
    .div_done_i     (div_done),
    .div_quot_i     (div_quot),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .covariance_o   (covariance_o),
    .row_mean_o     (row_mean_o),
    .sample_count_o (sample_count_o)
  );

  // divider is never restarted while a division is running
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_start |-> !div_busy)
    else $error("divider started while busy");

  // back only pops a queued command
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> cmd_valid)
    else $error("pop from empty command queue");

  // divider reports done only once it has gone idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |-> !div_busy)
    else $error("divider done while still busy");

endmodule
